FILE: rtl/assert_macros.svh
// assertion macros used by the keyboard report builder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/kbr_pkg.sv
// types and constants of the keyboard report builder
`default_nettype none
package kbr_pkg;
  localparam int MAP_BYTES  = 32;
  localparam int MAP_AW     = 5;
  localparam int SLOT_COUNT = 6;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int POS_W      = 5;

  localparam logic [MAP_AW-1:0] MODIFIER_BYTE = 5'd28;
  localparam logic [2:0]        BIT_MASK      = 3'h7;
  localparam logic [7:0]        RESERVED_BYTE = 8'h00;
  localparam logic [7:0]        EMPTY_SLOT    = 8'h00;
  localparam logic [POS_W-1:0]  MAP_LAST      = POS_W'(MAP_BYTES - 1);
  localparam logic [POS_W-1:0]  BOOT_LAST     = POS_W'(SLOT_COUNT + 1);

  localparam logic [1:0] REQ_KEY    = 2'd0;
  localparam logic [1:0] REQ_COMMIT = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_MAP,
    ST_SLOT_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] key_code;
    logic       pressed;
    logic       configured;
  } req_item_t;

  typedef struct packed {
    logic [7:0]       report_byte;
    logic [POS_W-1:0] byte_index;
    logic             last_byte;
  } rpt_item_t;
endpackage
`default_nettype wire

FILE: rtl/kbr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module kbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/keyboard_report_builder.sv
// keyboard report builder top level: key bitmap, boot slots and report output
`default_nettype none
`include "assert_macros.svh"
// Keeps the 256-key bitmap in a 32x8 RAM and the boot slots in a SLOT_COUNT x 8 RAM,
// each entry guarded by a valid bit cleared at reset, so no clearing pass is needed.
// A commit request, an ignored request and a frame tick that sends nothing are
// handled in the idle state. A key event reads its bitmap byte, then writes it back
// in report protocol; in boot protocol it adds a slot scan of one slot a cycle
// through the slot RAM (code zero skips the scan). Each report byte is read from
// RAM, then loaded into the output register, the load waiting while the output
// stalls; the bitmap report has 32 bytes and the boot report 2 + SLOT_COUNT. New
// requests are taken only when the previous one is done, while the last report
// byte may still wait in the output.
module keyboard_report_builder (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  kbr_pkg::req_item_t req_data,
  output logic               rpt_valid,
  input  logic               rpt_ready,
  output kbr_pkg::rpt_item_t rpt_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import kbr_pkg::*;

  state_t state, state_next;
  req_item_t cur;
  logic boot_mode;
  logic pending;
  logic [MAP_BYTES-1:0] map_valid;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [SLOT_AW-1:0] sidx, sidx_next;
  logic [POS_W-1:0] pos, pos_next;

  logic map_we, map_ok;
  logic [MAP_AW-1:0] map_raddr;
  logic [7:0] map_wdata, map_rdata, map_v;
  logic slot_we, slot_ok;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [7:0] slot_wdata, slot_rdata, slot_v;

  logic accept, start_emit, slot_hit, slot_end, out_free, emit_last, load;
  logic [7:0] key_bit, emit_byte;

  assign req_ready  = (state == ST_IDLE);
  assign accept     = req_valid && req_ready;
  assign start_emit = accept && (req_data.req_type == REQ_TICK) && req_data.configured
                      && pending;
  assign map_v      = map_ok ? map_rdata : 8'h00;
  assign slot_v     = slot_ok ? slot_rdata : EMPTY_SLOT;
  assign slot_hit   = (slot_v == (cur.pressed ? EMPTY_SLOT : cur.key_code));
  assign slot_end   = (sidx == SLOT_AW'(SLOT_COUNT - 1));
  assign out_free   = !rpt_valid || rpt_ready;
  assign emit_last  = boot_mode ? (pos == BOOT_LAST) : (pos == MAP_LAST);
  assign load       = (state == ST_EMIT_LD) && out_free;
  assign key_bit    = 8'(1) << (cur.key_code[2:0] & BIT_MASK);

  kbr_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (cur.key_code[7:3]),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  kbr_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (sidx),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req_data.req_type == REQ_KEY) begin
          state_next = ST_KEY_MAP;
        end else if (start_emit) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_KEY_MAP: begin
        if (boot_mode && cur.key_code != EMPTY_SLOT) begin
          state_next = ST_SLOT_CHK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SLOT_CHK: begin
        if (slot_hit || slot_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    map_we     = 1'b0;
    map_wdata  = cur.pressed ? (map_v | key_bit) : (map_v & ~key_bit);
    slot_we    = 1'b0;
    slot_wdata = cur.pressed ? cur.key_code : EMPTY_SLOT;
    sidx_next  = '0;
    pos_next   = pos;
    map_raddr  = boot_mode ? MODIFIER_BYTE : pos[MAP_AW-1:0];
    slot_raddr = (boot_mode && pos >= POS_W'(2)) ? SLOT_AW'(pos - POS_W'(2)) : '0;
    unique case (state)
      ST_IDLE: begin
        map_raddr  = req_data.key_code[7:3];
        slot_raddr = '0;
        pos_next   = '0;
      end
      ST_KEY_MAP: begin
        map_we     = 1'b1;
        slot_raddr = '0;
      end
      ST_SLOT_CHK: begin
        slot_we = slot_hit;
        if (!(slot_hit || slot_end)) begin
          sidx_next = sidx + SLOT_AW'(1);
        end
        slot_raddr = sidx_next;
      end
      ST_EMIT_RD: begin
      end
      ST_EMIT_LD: begin
        if (load && !emit_last) begin
          pos_next = pos + POS_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (boot_mode && pos == POS_W'(0)) begin
      emit_byte = map_v;
    end else if (boot_mode && pos == POS_W'(1)) begin
      emit_byte = RESERVED_BYTE;
    end else if (boot_mode) begin
      emit_byte = slot_v;
    end else begin
      emit_byte = map_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      boot_mode  <= 1'b0;
      pending    <= 1'b0;
      map_valid  <= '0;
      slot_valid <= '0;
      sidx       <= '0;
      pos        <= '0;
      rpt_valid  <= 1'b0;
    end else begin
      state <= state_next;
      sidx  <= sidx_next;
      pos   <= pos_next;
      if (cfg_we) begin
        boot_mode <= cfg_wdata;
      end
      if (accept && req_data.req_type == REQ_COMMIT) begin
        pending <= 1'b1;
      end else if (start_emit) begin
        pending <= 1'b0;
      end
      if (map_we) begin
        map_valid[cur.key_code[7:3]] <= 1'b1;
      end
      if (slot_we) begin
        slot_valid[sidx] <= 1'b1;
      end
      if (load) begin
        rpt_valid <= 1'b1;
      end else if (rpt_ready) begin
        rpt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    map_ok  <= map_valid[map_raddr];
    slot_ok <= slot_valid[slot_raddr];
    if (accept) begin
      cur <= req_data;
    end
    if (load) begin
      rpt_data.report_byte <= emit_byte;
      rpt_data.byte_index  <= pos;
      rpt_data.last_byte   <= emit_last;
    end
  end

  `ASSERT_IMPLY(a_rpt_from_load, clk, rst, $rose(rpt_valid), $past(state) == ST_EMIT_LD)
  `ASSERT_NEXT(a_last_ends_emit, clk, rst, load && emit_last, state == ST_IDLE)
  `ASSERT_IMPLY(a_slot_boot_only, clk, rst, slot_we, boot_mode && cur.key_code != EMPTY_SLOT)
endmodule
`default_nettype wire
